// ===== src/xtnp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xtnp_pkg;

  // Payload field widths
  localparam int VALUE_W = 32;
  localparam int POS_W   = 10;
  localparam int SPAN_W  = 11;

  // Default sizing
  localparam int DEF_MAX_ITEMS  = 1024;
  localparam int DEF_VALUE_BITS = 32;

  // Per-cell control, broadcast along the chain
  typedef struct packed {
    logic insert;   // shift a new value in at the head
    logic rotate;   // circulate the occupied ring by one cell
    logic clear;    // drop the tail marker (start of a new case)
  } xtnp_cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/xtnp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface xtnp_in_if import xtnp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               first_of_case;

  modport source (output valid, output value, output first_of_case, input ready);
  modport sink   (input valid, input value, input first_of_case, output ready);
endinterface

`default_nettype wire

// ===== src/xtnp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface xtnp_out_if import xtnp_pkg::*;;
  logic              valid;
  logic              ready;
  logic              partner_found;
  logic [POS_W-1:0]  partner_position;
  logic              best_found;
  logic [SPAN_W-1:0] best_span;
  logic              overflow;

  modport source (output valid, output partner_found, output partner_position,
                  output best_found, output best_span, output overflow, input ready);
  modport sink   (input valid, input partner_found, input partner_position,
                  input best_found, input best_span, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/xtnp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xtnp_cell import xtnp_pkg::*; #(
  parameter int VW = VALUE_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  xtnp_cell_ctl_t ctl,
  input  logic [VW-1:0]  prev_value,
  input  logic           prev_tail,
  input  logic [VW-1:0]  next_value,
  input  logic [VW-1:0]  head_value,
  output logic [VW-1:0]  value_o,
  output logic           tail_o
);

  logic [VW-1:0] value_r, value_nxt;
  logic          tail_r, tail_nxt;

  always_comb begin
    value_nxt = value_r;
    tail_nxt  = tail_r;
    if (ctl.insert) begin
      value_nxt = prev_value;
      tail_nxt  = prev_tail & ~ctl.clear;
    end else if (ctl.rotate) begin
      // the tail cell closes the ring back to the head
      value_nxt = tail_r ? head_value : next_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= 1'b0;
    end else begin
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;
  assign tail_o  = tail_r;

endmodule

`default_nettype wire

// ===== src/xor_threshold_nearest_partner_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake         Payload
// in_ch     in   valid/ready       value[31:0], first_of_case
// out_ch    out  valid/ready       partner_found, partner_position[9:0], best_found,
//                                  best_span[10:0], overflow
// cfg       in   cfg_we            cfg_wdata[31:0] -> threshold
//
// A stored request is shifted into the cell chain on accept; ST_SCAN then rotates the
// occupied ring of N cells, N being the item count after the insert, all the way round
// past the single XOR/compare at the head cell, and ST_DLV loads the output register.
// A refused (overflow) request goes straight to ST_DLV. in_ch.ready is high only when idle.
// The output register holds a result while out_ch.ready is low; the block then waits.
// Synchronous reset clears counters, best span, threshold and the tail marker.
module xor_threshold_nearest_partner_unit import xtnp_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  xtnp_in_if.sink            in_ch,
  xtnp_out_if.source         out_ch
);

  localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DLV  = 2'd2;

  logic [1:0]        state_r;
  logic [CW-1:0]     count_r;
  logic [PW-1:0]     cur_r;
  logic [PW-1:0]     j_r;
  logic [VW-1:0]     v_r;
  logic [VW-1:0]     thr_r;
  logic              hit_r;
  logic [POS_W-1:0]  hit_pos_r;
  logic [SPAN_W-1:0] hit_span_r;
  logic              best_valid_r;
  logic [SPAN_W-1:0] best_span_r;
  logic              res_found_r;
  logic [POS_W-1:0]  res_pos_r;
  logic              res_ovf_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_best_found_r;
  logic [SPAN_W-1:0] out_best_span_r;
  logic              out_ovf_r;

  logic              accept;
  logic [CW-1:0]     count_eff;
  logic              full;
  logic              match;
  logic              scan_last;
  logic [CW-1:0]     j_plus;
  logic              hit_now;
  logic [SPAN_W-1:0] span_now;
  logic [POS_W-1:0]  pos_now;
  logic              best_upd;

  xtnp_cell_ctl_t    ctl_body, ctl_head;
  logic [VW-1:0]     cell_val  [MAX_ITEMS];
  logic              cell_tail [MAX_ITEMS];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid & in_ch.ready;
  assign count_eff   = in_ch.first_of_case ? '0 : count_r;
  assign full        = (count_eff == FULL_COUNT);

  assign ctl_body.insert = accept & ~full;
  assign ctl_body.rotate = (state_r == ST_SCAN);
  assign ctl_body.clear  = in_ch.first_of_case;
  assign ctl_head.insert = ctl_body.insert;
  assign ctl_head.rotate = ctl_body.rotate;
  assign ctl_head.clear  = 1'b0;

  // Outside a scan, cell 0 holds the newest value; cell k holds position count-1-k.
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    if (k == 0) begin : g_head
      xtnp_cell #(.VW(VW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_head),
        .prev_value (VW'(in_ch.value)),
        .prev_tail  (count_eff == '0),
        .next_value ((MAX_ITEMS > 1) ? cell_val[(k + 1) % MAX_ITEMS] : cell_val[0]),
        .head_value (cell_val[0]),
        .value_o    (cell_val[k]),
        .tail_o     (cell_tail[k])
      );
    end else if (k == MAX_ITEMS - 1) begin : g_last
      xtnp_cell #(.VW(VW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_body),
        .prev_value (cell_val[k-1]),
        .prev_tail  (cell_tail[k-1]),
        .next_value (cell_val[0]),
        .head_value (cell_val[0]),
        .value_o    (cell_val[k]),
        .tail_o     (cell_tail[k])
      );
    end else begin : g_body
      xtnp_cell #(.VW(VW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_body),
        .prev_value (cell_val[k-1]),
        .prev_tail  (cell_tail[k-1]),
        .next_value (cell_val[k+1]),
        .head_value (cell_val[0]),
        .value_o    (cell_val[k]),
        .tail_o     (cell_tail[k])
      );
    end
  end

  // Scan step j looks at position cur-j, newest first.
  assign match     = ((cell_val[0] ^ v_r) >= thr_r);
  assign scan_last = (j_r == cur_r);
  assign j_plus    = CW'(j_r) + CW'(1);
  assign hit_now   = hit_r | match;
  assign span_now  = hit_r ? hit_span_r : SPAN_W'(j_plus);
  assign pos_now   = hit_r ? hit_pos_r : POS_W'(cur_r - j_r);
  assign best_upd  = hit_now & (~best_valid_r | (span_now < best_span_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      thr_r        <= '0;
      hit_r        <= 1'b0;
      best_valid_r <= 1'b0;
      best_span_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= VW'(cfg_wdata);
      end
      // in ST_DLV the output register is handled below
      if (out_ch.ready && (state_r != ST_DLV)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.first_of_case) begin
              best_valid_r <= 1'b0;
              best_span_r  <= '0;
            end
            if (full) begin
              res_found_r <= 1'b0;
              res_pos_r   <= '0;
              res_ovf_r   <= 1'b1;
              state_r     <= ST_DLV;
            end else begin
              count_r   <= count_eff + CW'(1);
              cur_r     <= count_eff[PW-1:0];
              j_r       <= '0;
              hit_r     <= 1'b0;
              v_r       <= VW'(in_ch.value);
              res_ovf_r <= 1'b0;
              state_r   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match & ~hit_r) begin
            hit_r      <= 1'b1;
            hit_pos_r  <= pos_now;
            hit_span_r <= span_now;
          end
          j_r <= j_r + PW'(1);
          // the ring must go all the way round to restore cell order
          if (scan_last) begin
            res_found_r <= hit_now;
            res_pos_r   <= hit_now ? pos_now : '0;
            if (best_upd) begin
              best_valid_r <= 1'b1;
              best_span_r  <= span_now;
            end
            state_r <= ST_DLV;
          end
        end
        ST_DLV: begin
          if (~out_valid_r | out_ch.ready) begin
            out_valid_r      <= 1'b1;
            out_found_r      <= res_found_r;
            out_pos_r        <= res_pos_r;
            out_best_found_r <= best_valid_r;
            out_best_span_r  <= best_valid_r ? best_span_r : '0;
            out_ovf_r        <= res_ovf_r;
            state_r          <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.partner_found    = out_found_r;
  assign out_ch.partner_position = out_pos_r;
  assign out_ch.best_found       = out_best_found_r;
  assign out_ch.best_span        = out_best_span_r;
  assign out_ch.overflow         = out_ovf_r;

endmodule

`default_nettype wire

// ===== src/xtnp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xtnp_checker import xtnp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              partner_found,
  input logic [POS_W-1:0]  partner_position,
  input logic              best_found,
  input logic [SPAN_W-1:0] best_span,
  input logic              overflow
);

  // a result waiting on a stalled sink must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(partner_found)
      && $stable(partner_position) && $stable(best_span) && $stable(overflow))
    else $error("result changed while stalled");

  // a refused request never reports a partner
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> !partner_found && partner_position == '0)
    else $error("overflow result carries a partner");

  // no partner means position zero; no best means span zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (partner_found || partner_position == '0)
      && (best_found || best_span == '0))
    else $error("unused result field not zero");

  // a partner found in this request implies a best span exists
  a_best_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && partner_found |-> best_found)
    else $error("partner found without best span");

  // one request at a time: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");

endmodule

bind xor_threshold_nearest_partner_unit xtnp_checker u_xtnp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .partner_found    (out_ch.partner_found),
  .partner_position (out_ch.partner_position),
  .best_found       (out_ch.best_found),
  .best_span        (out_ch.best_span),
  .overflow         (out_ch.overflow)
);

`default_nettype wire

// ===== sim/xor_threshold_nearest_partner_unit_tb.sv =====
`timescale 1ns / 1ps

module xor_threshold_nearest_partner_unit_tb;
  import xtnp_pkg::*;

  localparam int CASE_DEPTH  = DEF_MAX_ITEMS;
  localparam int CYCLE_LIMIT = 10_000_000;
  // worst request: full ring rotation plus shift-in and output load
  localparam int DRAIN_WAIT  = DEF_MAX_ITEMS + 80;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               first_of_case;
    bit                 wait_idle;
  } partner_req_t;

  typedef struct packed {
    logic              partner_found;
    logic [POS_W-1:0]  partner_position;
    logic              best_found;
    logic [SPAN_W-1:0] best_span;
    logic              overflow;
  } partner_rpt_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [VALUE_W-1:0] cfg_wdata;

  xtnp_in_if  in_ch ();
  xtnp_out_if out_ch ();

  xor_threshold_nearest_partner_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state
  logic [VALUE_W-1:0] case_vals [CASE_DEPTH];
  int unsigned        case_len;
  logic [SPAN_W-1:0]  shortest_span;
  bit                 have_span;
  logic [VALUE_W-1:0] xor_thr;

  partner_req_t       req_backlog [$];
  partner_rpt_t       partner_reports [$];
  logic [VALUE_W-1:0] case_history [$];

  int unsigned queued_cnt;
  int unsigned taken_cnt;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned gap_pct;
  int unsigned stall_pct;
  logic        in_took;

  function automatic partner_rpt_t find_partner(input logic [VALUE_W-1:0] v,
                                                input logic first);
    partner_rpt_t r;
    int unsigned  cur;
    int unsigned  hit;
    int unsigned  span;
    r = '0;
    hit = 0;
    if (first) begin
      case_len = 0;
      shortest_span = '0;
      have_span = 1'b0;
    end
    if (case_len >= CASE_DEPTH) begin
      r.overflow = 1'b1;
    end else begin
      cur = case_len;
      case_vals[cur] = v;
      case_len = cur + 1;
      // newest first, so the first hit is the latest partner
      for (int j = int'(cur); j >= 0 && !r.partner_found; j--) begin
        if ((case_vals[j] ^ v) >= xor_thr) begin
          r.partner_found = 1'b1;
          hit = j;
        end
      end
      if (r.partner_found) begin
        span = cur - hit + 1;
        if (!have_span || span[SPAN_W-1:0] < shortest_span) begin
          shortest_span = span[SPAN_W-1:0];
          have_span = 1'b1;
        end
        r.partner_position = hit[POS_W-1:0];
      end
    end
    r.best_found = have_span;
    r.best_span = have_span ? shortest_span : '0;
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin
    partner_rpt_t want;
    if (!rst_n) begin
      case_len = 0;
      shortest_span = '0;
      have_span = 1'b0;
      xor_thr = '0;
      in_took <= 1'b0;
    end else begin
      if (cfg_we) xor_thr = cfg_wdata;
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        partner_reports.insert(partner_reports.size(),
                               find_partner(in_ch.value, in_ch.first_of_case));
        taken_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (partner_reports.size() == 0) begin
          $display("%0t: unexpected result, got found=%0d pos=%0d best=%0d span=%0d ovf=%0d",
                   $time, out_ch.partner_found, out_ch.partner_position,
                   out_ch.best_found, out_ch.best_span, out_ch.overflow);
          mismatches++;
        end else begin
          want = partner_reports.pop_front();
          check_field("partner_found", want.partner_found, out_ch.partner_found);
          check_field("partner_position", want.partner_position, out_ch.partner_position);
          check_field("best_found", want.best_found, out_ch.best_found);
          check_field("best_span", want.best_span, out_ch.best_span);
          check_field("overflow", want.overflow, out_ch.overflow);
        end
      end
    end
  end

  // driver: holds a request until taken, idles at random between requests
  always @(negedge clk) begin
    partner_req_t nxt;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (in_ch.valid && !in_took) begin
      // hold
    end else if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct &&
                 !(req_backlog[0].wait_idle && partner_reports.size() != 0)) begin
      nxt = req_backlog.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.value <= nxt.value;
      in_ch.first_of_case <= nxt.first_of_case;
    end else begin
      in_ch.valid <= 1'b0;
      in_ch.value <= $urandom();
      in_ch.first_of_case <= $urandom_range(1);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_req(input logic [VALUE_W-1:0] v, input logic first,
                           input bit wait_idle);
    partner_req_t r;
    r.value = v;
    r.first_of_case = first;
    r.wait_idle = wait_idle;
    if (first) case_history.delete();
    case_history.insert(case_history.size(), v);
    req_backlog.insert(req_backlog.size(), r);
    queued_cnt++;
  endtask

  task automatic drain();
    while (taken_cnt != queued_cnt || partner_reports.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [VALUE_W-1:0] thr);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= $urandom();
  endtask

  // values biased toward complements and near-copies of earlier ones in the case
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] base;
    int unsigned        sel;
    sel = $urandom_range(99);
    if (case_history.size() == 0 || sel < 30) return $urandom();
    base = case_history[$urandom_range(case_history.size() - 1)];
    if (sel < 55) begin
      if ($urandom_range(3) == 0) return ~base ^ (32'h1 << $urandom_range(31));
      return ~base;
    end
    if (sel < 75) return base ^ ($urandom() >> $urandom_range(31));
    if (sel < 85) return base;
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_cases(input int unsigned n);
    int unsigned left;
    int unsigned len;
    int unsigned pick;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(40, 9);
      else len = $urandom_range(120, 41);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        queue_req(pick_value(), k == 0 && $urandom_range(9) != 0, $urandom_range(49) == 0);
      end
      left -= len;
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] thr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.first_of_case = 1'b0;
    out_ch.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    queued_cnt = 0;
    taken_cnt = 0;
    mismatches = 0;
    cycle_cnt = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero threshold out of reset: every value is its own partner
    queue_req(32'h0000_0000, 1'b0, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(32'h1234_5678, 1'b1, 1'b1);
    drain();

    // all-ones threshold: only exact complements match
    write_threshold(32'hFFFF_FFFF);
    queue_req(32'h0000_0000, 1'b1, 1'b0);
    queue_req(32'h0000_0000, 1'b0, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(32'hA5A5_A5A5, 1'b0, 1'b0);
    queue_req(32'h5A5A_5A5A, 1'b0, 1'b0);
    queue_req(32'h0000_0000, 1'b0, 1'b0);
    drain();

    write_threshold(32'h8000_0000);
    queue_req(32'h7FFF_FFFF, 1'b1, 1'b0);
    queue_req(32'h8000_0000, 1'b0, 1'b0);
    queue_req(32'h0000_0001, 1'b0, 1'b0);
    queue_req(32'hFFFF_FFFE, 1'b1, 1'b0);
    queue_req(32'h7FFF_FFFE, 1'b0, 1'b0);
    drain();

    write_threshold(32'h0000_0001);
    queue_req(32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_req(32'hFFFF_FFFE, 1'b0, 1'b0);
    drain();

    // random phases, cycling through the idling modes
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: thr = 32'h8000_0000;
        1: thr = 32'hFFFF_FFFF;
        2: thr = 32'h0000_0000;
        3: thr = 32'hF000_0000;
        default: thr = $urandom();
      endcase
      write_threshold(thr);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      random_cases(75);
      drain();
    end

    // one case filled past capacity, then a fresh case
    write_threshold(32'hC000_0000 | ($urandom() >> 2));
    gap_pct = 14;
    stall_pct = 14;
    queue_req(pick_value(), 1'b1, 1'b0);
    for (int k = 1; k < CASE_DEPTH + 6; k++) queue_req(pick_value(), 1'b0, 1'b0);
    queue_req(pick_value(), 1'b1, 1'b0);
    for (int k = 0; k < 5; k++) queue_req(pick_value(), 1'b0, 1'b0);
    drain();

    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
